// File: src/mtbe_pkg.sv
// shared types and constants of the manchester tape block encoder
`default_nettype none

package mtbe_pkg;

  // command codes carried in the input tuser
  typedef enum logic [2:0] {
    OP_PILOT = 3'd0,
    OP_MARK  = 3'd1,
    OP_FLAG  = 3'd2,
    OP_DATA  = 3'd3,
    OP_FINAL = 3'd4,
    OP_CHK   = 3'd5,
    OP_GAP   = 3'd6,
    OP_NOP   = 3'd7
  } op_e;

  // what the back end does with a queued job
  typedef enum logic [1:0] {
    KIND_PILOT = 2'd0,
    KIND_MARK  = 2'd1,
    KIND_BITS  = 2'd2,
    KIND_GAP   = 2'd3
  } kind_e;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] REG_HALF  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PILOT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MARK  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAP   = 2'd3;

  localparam int unsigned HALF_W = 16;
  localparam int unsigned DUR_W  = 24;
  localparam int unsigned SUM_W  = 16;
  localparam int unsigned BYTE_W = 8;

  localparam logic [HALF_W-1:0] HALF_RST  = 16'd80;
  localparam logic [HALF_W-1:0] PILOT_RST = 16'd160;
  localparam logic [HALF_W-1:0] MARK_RST  = 16'd400;
  localparam logic [DUR_W-1:0]  GAP_RST   = 24'd96000;

  // pilot group: 0 then 1 then 1, lsb first
  localparam logic [15:0] PILOT_BITS = 16'h0006;
  localparam logic [3:0]  PILOT_NM1  = 4'd2;
  localparam logic [3:0]  BYTE_NM1   = 4'd7;
  localparam logic [3:0]  FINAL_NM1  = 4'd6;
  localparam logic [3:0]  CHK_NM1    = 4'd15;

  typedef struct packed {
    logic [HALF_W-1:0] half;
    logic [HALF_W-1:0] pilot;
    logic [HALF_W-1:0] mark;
    logic [DUR_W-1:0]  gap;
  } cfg_t;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] bits;  // manchester bits, lsb goes first
    logic [3:0]  nm1;   // number of bits minus one
  } job_t;

endpackage

`default_nettype wire

// File: src/mtbe_front.sv
// command front end: classifies commands, keeps the running sum, builds jobs
`default_nettype none

module mtbe_front
  import mtbe_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cfg_t              cfg_i,
  input  wire logic              acc_i,
  input  wire logic [2:0]        opcode_i,
  input  wire logic [BYTE_W-1:0] data_byte_i,
  output job_t                   job_o,
  output logic                   push_o
);

  logic [SUM_W-1:0] sum_q, sum_d;
  logic [SUM_W-1:0] byte_ext;
  op_e              op;

  assign op       = op_e'(opcode_i);
  assign byte_ext = {{(SUM_W-BYTE_W){1'b0}}, data_byte_i};

  always_comb begin
    sum_d      = sum_q;
    job_o.kind = KIND_BITS;
    job_o.bits = {8'h00, data_byte_i};
    job_o.nm1  = BYTE_NM1;
    push_o     = 1'b0;
    case (op)
      OP_PILOT: begin
        job_o.kind = KIND_PILOT;
        job_o.bits = PILOT_BITS;
        job_o.nm1  = PILOT_NM1;
        push_o     = acc_i;
      end
      OP_MARK: begin
        job_o.kind = KIND_MARK;
        job_o.bits = 16'h0001;
        job_o.nm1  = '0;
        push_o     = acc_i;
      end
      OP_FLAG: begin
        if (acc_i) sum_d = byte_ext;
        push_o = acc_i;
      end
      OP_DATA: begin
        if (acc_i) sum_d = sum_q + byte_ext;
        push_o = acc_i;
      end
      OP_FINAL: begin
        if (acc_i) sum_d = sum_q + byte_ext;
        job_o.nm1 = FINAL_NM1;
        push_o    = acc_i;
      end
      OP_CHK: begin
        job_o.bits = sum_q;
        job_o.nm1  = CHK_NM1;
        push_o     = acc_i;
      end
      OP_GAP: begin
        job_o.kind = KIND_GAP;
        job_o.bits = '0;
        job_o.nm1  = '0;
        // zero gap gives no segment at all
        push_o     = acc_i && (cfg_i.gap != '0);
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

endmodule

`default_nettype wire

// File: src/mtbe_fifo.sv
// short job queue between front and back end
`default_nettype none

module mtbe_fifo
  import mtbe_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t wdata_i,
  input  wire logic pop_i,
  output job_t      rdata_o,
  output logic      full_o,
  output logic      valid_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          mem_q [DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    if (pop_i)  rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    if (!push_i && pop_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= wdata_i;
  end

endmodule

`default_nettype wire

// File: src/mtbe_back.sv
// segment sequencer: walks a job half period by half period into the output register
`default_nettype none

module mtbe_back
  import mtbe_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cfg_t       cfg_i,
  input  wire job_t       job_i,
  input  wire logic       job_valid_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            out_level_o,
  output logic [DUR_W-1:0] out_dur_o,
  output logic            out_last_o
);

  logic             busy_q, busy_d;
  job_t             job_q, job_d;
  logic [3:0]       idx_q, idx_d;
  logic             ph_q, ph_d;
  logic             ovalid_q, ovalid_d;
  logic             olevel_q, olevel_d;
  logic [DUR_W-1:0] odur_q, odur_d;
  logic             olast_q, olast_d;

  logic             can_emit;
  logic             seg_level;
  logic [DUR_W-1:0] seg_dur;
  logic             seg_last;

  assign can_emit = !ovalid_q || out_ready_i;
  assign pop_o    = !busy_q && job_valid_i;

  always_comb begin
    seg_level = job_q.bits[idx_q] ^ ph_q;
    seg_dur   = {8'h00, cfg_i.half};
    seg_last  = ph_q && (idx_q == job_q.nm1);
    case (job_q.kind)
      KIND_GAP: begin
        seg_level = 1'b0;
        seg_dur   = cfg_i.gap;
        seg_last  = 1'b1;
      end
      KIND_MARK: begin
        seg_dur = {8'h00, cfg_i.mark};
      end
      KIND_PILOT: begin
        // only the leading zero bit is stretched
        if (idx_q == '0) seg_dur = {8'h00, cfg_i.pilot};
      end
      default: begin
        seg_dur = {8'h00, cfg_i.half};
      end
    endcase
  end

  always_comb begin
    busy_d   = busy_q;
    job_d    = job_q;
    idx_d    = idx_q;
    ph_d     = ph_q;
    ovalid_d = ovalid_q;
    olevel_d = olevel_q;
    odur_d   = odur_q;
    olast_d  = olast_q;
    if (out_ready_i) ovalid_d = 1'b0;
    if (pop_o) begin
      busy_d = 1'b1;
      job_d  = job_i;
      idx_d  = '0;
      ph_d   = 1'b0;
    end else if (busy_q && can_emit) begin
      ovalid_d = 1'b1;
      olevel_d = seg_level;
      odur_d   = seg_dur;
      olast_d  = seg_last;
      if (seg_last) begin
        busy_d = 1'b0;
      end else if (ph_q) begin
        ph_d  = 1'b0;
        idx_d = idx_q + 1'b1;
      end else begin
        ph_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      ovalid_q <= 1'b0;
      idx_q    <= '0;
      ph_q     <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      ovalid_q <= ovalid_d;
      idx_q    <= idx_d;
      ph_q     <= ph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q    <= job_d;
    olevel_q <= olevel_d;
    odur_q   <= odur_d;
    olast_q  <= olast_d;
  end

  assign out_valid_o = ovalid_q;
  assign out_level_o = olevel_q;
  assign out_dur_o   = odur_q;
  assign out_last_o  = olast_q;

endmodule

`default_nettype wire

// File: src/manchester_tape_block_encoder_core.sv
// top level of the manchester tape block encoder
`default_nettype none

// Turns tape framing commands into Manchester half-period segments
// (level, duration in samples), bits lsb first, with a 16-bit additive
// checksum kept across flag, data and final bytes. A front end takes one
// command per cycle while the job queue has room, updates the running sum
// and queues a job; a back-end sequencer loads each job, emitting nothing
// as it does so, and then plays it out as one segment per cycle through a
// registered output, so the output bus sets the pace. A command gives
// pilot 6, mark 2, byte 16, final 14, checksum 32 or gap 1 segments. No-op
// and a zero-length gap are accepted but leave nothing. Commands keep
// being accepted while the job queue (DEPTH entries) has room, including
// while a finished segment waits on m_axis_tready. tlast marks the final
// segment of each command. Configuration writes belong in idle periods.
module manchester_tape_block_encoder_core
  import mtbe_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration write port
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // command beats
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [7:0]            s_axis_tdata,   // [7:0] data_byte
  input  wire logic [2:0]            s_axis_tuser,   // [2:0] opcode
  // segment beats
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [31:0]                m_axis_tdata,   // [0] level, [24:1] duration, zero above
  output logic                       m_axis_tlast
);

  cfg_t cfg_q;

  // config registers, writes beyond the list do nothing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half  <= HALF_RST;
      cfg_q.pilot <= PILOT_RST;
      cfg_q.mark  <= MARK_RST;
      cfg_q.gap   <= GAP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_HALF:  cfg_q.half  <= cfg_data_i[HALF_W-1:0];
        REG_PILOT: cfg_q.pilot <= cfg_data_i[HALF_W-1:0];
        REG_MARK:  cfg_q.mark  <= cfg_data_i[HALF_W-1:0];
        REG_GAP:   cfg_q.gap   <= cfg_data_i[DUR_W-1:0];
        default:   cfg_q.gap   <= cfg_q.gap;
      endcase
    end
  end

  logic             s_acc;
  logic             fe_push;
  job_t             fe_job;
  job_t             q_job;
  logic             q_full;
  logic             q_valid;
  logic             be_pop;
  logic             out_level;
  logic [DUR_W-1:0] out_dur;

  // front only stalls on a full queue
  assign s_axis_tready = !q_full;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  mtbe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .acc_i       (s_acc),
    .opcode_i    (s_axis_tuser),
    .data_byte_i (s_axis_tdata),
    .job_o       (fe_job),
    .push_o      (fe_push)
  );

  mtbe_fifo #(
    .DEPTH (DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fe_push),
    .wdata_i (fe_job),
    .pop_i   (be_pop),
    .rdata_o (q_job),
    .full_o  (q_full),
    .valid_o (q_valid)
  );

  mtbe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_i       (q_job),
    .job_valid_i (q_valid),
    .pop_o       (be_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_level_o (out_level),
    .out_dur_o   (out_dur),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {7'd0, out_dur, out_level};

  // queue never written while full
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fe_push |-> !q_full)
    else $error("job queue written while full");

  // sequencer only loads a job that is present
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    be_pop |-> q_valid)
    else $error("job queue read while empty");

  // no-op commands never produce a job
  a_nop_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && (s_axis_tuser == OP_NOP)) |-> !fe_push)
    else $error("no-op command queued a job");

endmodule

`default_nettype wire
